// ===== sv/assert_macros.svh =====
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define ASSERT_CLK(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/tcb_pkg.sv =====
package tcb_pkg;

  localparam logic [3:0] REQ_PUSH      = 4'd0;
  localparam logic [3:0] REQ_TRY       = 4'd1;
  localparam logic [3:0] REQ_PULL      = 4'd2;
  localparam logic [3:0] REQ_DISCARD   = 4'd3;
  localparam logic [3:0] REQ_RETRY     = 4'd4;
  localparam logic [3:0] REQ_SET_ALL   = 4'd5;
  localparam logic [3:0] REQ_PRELOAD   = 4'd6;
  localparam logic [3:0] REQ_ADV_IN    = 4'd7;
  localparam logic [3:0] REQ_FIND      = 4'd8;
  localparam logic [3:0] REQ_ADV_TRIAL = 4'd9;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] count;
    logic [31:0] seq_value;
  } tcb_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] done_count;
    logic [11:0] found_offset;
    logic [11:0] stored_len;
    logic [11:0] untried_len;
    logic [11:0] tried_len;
    logic [11:0] free_len;
  } tcb_rsp_t;

endpackage

// ===== sv/tcp_circular_buffer_with_trial_pointer_core.sv =====
// pointer-only requests, push and preload: result registered, or parked while output stalls
// try and pull: the ring read is registered, then S_READ forwards the byte
// find delimiter: S_SCAN checks stored bytes from the oldest to a match or the last byte
// throughput: one pointer-only word a cycle if output not stalled; try, pull, find stall input
// reset: all three sequence pointers cleared; ring contents stay undefined, no clearing pass
`include "assert_macros.svh"

module tcp_circular_buffer_with_trial_pointer_core #(
  parameter int RING_SIZE = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcb_pkg::tcb_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcb_pkg::tcb_rsp_t  out_data_o
);
  import tcb_pkg::*;

  localparam int AW = $clog2(RING_SIZE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  function automatic logic [AW-1:0] ring_dist(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[AW-1:0];
  endfunction

  function automatic logic [15:0] clip(input logic [15:0] a, input logic [AW-1:0] b);
    return (a < 16'(b)) ? a : 16'(b);
  endfunction

  logic [7:0]    ring [RING_SIZE];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  logic [1:0]    state_q, state_d;
  logic [31:0]   in_seq_q, in_seq_d;
  logic [31:0]   trial_seq_q, trial_seq_d;
  logic [31:0]   out_seq_q, out_seq_d;
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [7:0]    delim_q, delim_d;
  tcb_rsp_t      rsp_q, hold_q, hold_d, res;
  logic          rsp_valid_q;
  logic          fin;
  logic          busy;
  logic          acc;

  logic [AW-1:0] stored, untried, tried, free;
  logic [AW-1:0] scan_nxt;

  assign stored   = ring_dist(in_seq_q, out_seq_q);
  assign untried  = ring_dist(in_seq_q, trial_seq_q);
  assign tried    = ring_dist(trial_seq_q, out_seq_q);
  assign free     = ~stored;
  assign scan_nxt = scan_idx_q + 1'b1;

  assign busy       = rsp_valid_q && out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    logic [15:0] n;
    logic [31:0] out_new;
    logic [31:0] seq_off;
    n           = '0;
    out_new     = out_seq_q;
    seq_off     = in_data_i.seq_value - in_seq_q;
    state_d     = state_q;
    in_seq_d    = in_seq_q;
    trial_seq_d = trial_seq_q;
    out_seq_d   = out_seq_q;
    scan_idx_d  = scan_idx_q;
    delim_d     = delim_q;
    hold_d      = hold_q;
    fin         = 1'b0;
    res         = '0;
    mem_we      = 1'b0;
    mem_wa      = in_seq_q[AW-1:0];
    mem_wd      = in_data_i.data_byte;
    rd_addr     = out_seq_q[AW-1:0] + scan_nxt;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.req_type)
            REQ_PUSH: begin
              fin = 1'b1;
              if (free != '0) begin
                mem_we         = 1'b1;
                in_seq_d       = in_seq_q + 32'd1;
                res.done_count = 16'd1;
              end
            end
            REQ_TRY: begin
              if (untried != '0) begin
                rd_addr     = trial_seq_q[AW-1:0];
                trial_seq_d = trial_seq_q + 32'd1;
                state_d     = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            REQ_PULL: begin
              if (stored != '0) begin
                rd_addr   = out_seq_q[AW-1:0];
                out_new   = out_seq_q + 32'd1;
                out_seq_d = out_new;
                if (untried > ring_dist(in_seq_q, out_new)) trial_seq_d = out_new;
                state_d = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            REQ_DISCARD: begin
              fin       = 1'b1;
              n         = clip(in_data_i.count, stored);
              out_new   = out_seq_q + 32'(n);
              out_seq_d = out_new;
              if (untried > ring_dist(in_seq_q, out_new)) trial_seq_d = out_new;
              res.done_count = n;
            end
            REQ_RETRY: begin
              fin            = 1'b1;
              n              = clip(in_data_i.count, tried);
              trial_seq_d    = trial_seq_q - 32'(n);
              res.done_count = n;
            end
            REQ_SET_ALL: begin
              fin         = 1'b1;
              in_seq_d    = in_data_i.seq_value;
              trial_seq_d = in_data_i.seq_value;
              out_seq_d   = in_data_i.seq_value;
            end
            REQ_PRELOAD: begin
              fin = 1'b1;
              if (seq_off < 32'(free)) begin
                mem_we         = 1'b1;
                mem_wa         = in_data_i.seq_value[AW-1:0];
                res.done_count = 16'd1;
              end
            end
            REQ_ADV_IN: begin
              fin            = 1'b1;
              n              = clip(in_data_i.count, free);
              in_seq_d       = in_seq_q + 32'(n);
              res.done_count = n;
            end
            REQ_FIND: begin
              if (stored != '0) begin
                rd_addr    = out_seq_q[AW-1:0];
                scan_idx_d = '0;
                delim_d    = in_data_i.data_byte;
                state_d    = S_SCAN;
              end else begin
                fin = 1'b1;
              end
            end
            REQ_ADV_TRIAL: begin
              fin            = 1'b1;
              n              = clip(in_data_i.count, untried);
              trial_seq_d    = trial_seq_q + 32'(n);
              res.done_count = n;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin            = 1'b1;
        res.read_byte  = rd_data_q;
        res.done_count = 16'd1;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        if (rd_data_q == delim_q) begin
          fin              = 1'b1;
          res.found_offset = 12'(scan_idx_q);
          state_d          = S_IDLE;
        end else if (scan_idx_q == stored - 1'b1) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          scan_idx_d = scan_nxt;
        end
      end
      S_HOLD: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // lengths always reflect the pointers after this word
    res.stored_len  = 12'(ring_dist(in_seq_d, out_seq_d));
    res.untried_len = 12'(ring_dist(in_seq_d, trial_seq_d));
    res.tried_len   = 12'(ring_dist(trial_seq_d, out_seq_d));
    res.free_len    = 12'(ring_dist(in_seq_d, out_seq_d) ^ {AW{1'b1}});

    // output register still occupied: park the result
    if (fin && busy) begin
      state_d = S_HOLD;
      hold_d  = res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ring[mem_wa] <= mem_wd;
    rd_data_q <= ring[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_seq_q    <= '0;
      trial_seq_q <= '0;
      out_seq_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_seq_q    <= in_seq_d;
      trial_seq_q <= trial_seq_d;
      out_seq_q   <= out_seq_d;
      if (fin && !busy) begin
        rsp_valid_q <= 1'b1;
      end else if (state_q == S_HOLD && !out_stall_i) begin
        rsp_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    delim_q    <= delim_d;
    hold_q     <= hold_d;
    if (fin && !busy) begin
      rsp_q <= res;
    end else if (state_q == S_HOLD && !out_stall_i) begin
      rsp_q <= hold_q;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

  `ASSERT_CLK(a_hold_has_output, (state_q == S_HOLD) |-> rsp_valid_q, "parked word lost")
  `ASSERT_CLK(a_trial_between, ({1'b0, tried} + {1'b0, untried}) == {1'b0, stored}, "trial lost")
  `ASSERT_CLK(a_scan_in_range, (state_q == S_SCAN) |-> (scan_idx_q < stored), "scan overrun")

endmodule
